[hdl/swept_box_object_collision_unit_macros.svh]
// Assertion helpers shared by the collision unit.
`ifndef SWEPT_BOX_OBJECT_COLLISION_UNIT_MACROS_SVH
`define SWEPT_BOX_OBJECT_COLLISION_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SBCU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication that must hold in the cycle after its trigger.
`define SBCU_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/sbcu_pkg.sv]
package sbcu_pkg;

	localparam int unsigned NUM_OBJECTS_DEF = 16;
	localparam int unsigned IDX_W = 8;
	localparam int unsigned EDGE_W = 16;
	localparam int unsigned WORLD_W = 15;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [WORLD_W-1:0] WORLD_RESET = 15'd16384;

	localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 8'd1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [3:0] HEAD_NONE = 4'd0;
	localparam logic [3:0] HEAD_UP = 4'd1;
	localparam logic [3:0] HEAD_DOWN = 4'd2;
	localparam logic [3:0] HEAD_LEFT = 4'd3;
	localparam logic [3:0] HEAD_RIGHT = 4'd4;
	localparam logic [3:0] HEAD_UPLEFT = 4'd5;
	localparam logic [3:0] HEAD_DOWNLEFT = 4'd6;
	localparam logic [3:0] HEAD_UPRIGHT = 4'd7;
	localparam logic [3:0] HEAD_DOWNRIGHT = 4'd8;

	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_HIT = 2'd1;
	localparam logic [1:0] STAT_OOB = 2'd2;

	typedef struct packed {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic valid;
		logic [3:0] slot;
		logic enable;
		box_t box;
	} wr_t;

	typedef struct packed {
		logic done;
		logic found;
		logic [IDX_W-1:0] idx;
		box_t box;
	} token_t;

endpackage

[hdl/sbcu_cell.sv]
module sbcu_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input sbcu_pkg::wr_t wr,
	input logic tok_vld_in,
	input sbcu_pkg::token_t tok_in,
	output logic tok_vld_out,
	output sbcu_pkg::token_t tok_out
);

	logic en_q;
	sbcu_pkg::box_t obj_q;
	logic tok_vld_q;
	sbcu_pkg::token_t tok_q;
	sbcu_pkg::token_t tok_nxt;
	logic wr_hit;
	logic overlap;

	assign wr_hit = wr.valid && (8'(wr.slot) == 8'(CELL_IDX));

	assign overlap = en_q
		&& ($signed(tok_in.box.left) <= $signed(obj_q.right))
		&& ($signed(tok_in.box.right) >= $signed(obj_q.left))
		&& ($signed(tok_in.box.top) <= $signed(obj_q.bottom))
		&& ($signed(tok_in.box.bottom) >= $signed(obj_q.top));

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.done && !tok_in.found && overlap) begin
			tok_nxt.found = 1'b1;
			tok_nxt.idx = 8'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_in;
			if (wr_hit) begin
				en_q <= wr.enable;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			obj_q <= wr.box;
		end
		tok_q <= tok_nxt;
	end

	assign tok_vld_out = tok_vld_q;
	assign tok_out = tok_q;

endmodule

[hdl/swept_box_object_collision_unit.sv]
// Swept-box collision unit.
// Input stream (s_*): s_tuser selects a slot write (0) or a query (1); s_tdata carries
// the slot, position, hitbox, enable, heading and speed. Writes update one object
// cell in the transfer cycle and give no result. A query yields one result on m_*:
// m_tuser is the status (0 no hit, 1 object hit, 2 out of bounds), m_tdata the slot.
// A query runs through a row of NUM_OBJECTS cells, one cell per cycle; its result passes
// through the head register, the cell row, the pending and the output register.
// One query is in flight at a time; s_tready stays low from a query transfer until
// its result has moved into the output register, so a new query is not taken before
// the last one is through, while writes are taken whenever s_tready is high.
// The cfg channel writes world width (index 0) and height (index 1); other indexes
// are dropped. cfg_ready is always high.
// Reset clears every enable bit, the world size to 16384 and all valid flags.
// A stalled receiver holds the result in the output register; the next item is still
// taken, and a further query waits in a pending register until the output drains.
module swept_box_object_collision_unit #(
	parameter int unsigned NUM_OBJECTS = sbcu_pkg::NUM_OBJECTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// [3:0] slot, [17:4] pos_x, [31:18] pos_y, [39:32] box_off_x, [47:40] box_off_y,
	// [55:48] box_width, [63:56] box_height, [64] enable, [68:65] heading, [76:69] speed
	input logic [79:0] s_tdata,
	// [0] func
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// [3:0] hit_slot
	output logic [7:0] m_tdata,
	// [1:0] status
	output logic [1:0] m_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sbcu_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sbcu_pkg::WORLD_W-1:0] cfg_data
);

	logic [sbcu_pkg::WORLD_W-1:0] world_w_q;
	logic [sbcu_pkg::WORLD_W-1:0] world_h_q;
	logic busy_q;
	logic in_xfer;
	logic [13:0] pos_x, pos_y;
	logic [7:0] off_x, off_y, size_w, size_h, speed;
	logic [3:0] heading;
	sbcu_pkg::box_t base_box;
	sbcu_pkg::box_t swept_box;
	sbcu_pkg::wr_t wr;
	logic head_vld_q;
	sbcu_pkg::box_t head_box_q;
	logic head_oob;
	logic tok_vld [0:NUM_OBJECTS];
	sbcu_pkg::token_t tok [0:NUM_OBJECTS];
	logic [NUM_OBJECTS-1:0] cell_vld;
	logic pend_vld_q;
	logic [1:0] pend_stat_q;
	logic [3:0] pend_slot_q;
	logic out_vld_q;
	logic [1:0] out_stat_q;
	logic [3:0] out_slot_q;
	logic out_free;
	logic [1:0] tail_stat;

	assign s_tready = !busy_q;
	assign in_xfer = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign pos_x = s_tdata[17:4];
	assign pos_y = s_tdata[31:18];
	assign off_x = s_tdata[39:32];
	assign off_y = s_tdata[47:40];
	assign size_w = s_tdata[55:48];
	assign size_h = s_tdata[63:56];
	assign heading = s_tdata[68:65];
	assign speed = s_tdata[76:69];

	always_comb begin
		base_box.left = 16'(pos_x) + 16'(off_x);
		base_box.top = 16'(pos_y) + 16'(off_y);
		base_box.right = base_box.left + 16'(size_w) - 16'd1;
		base_box.bottom = base_box.top + 16'(size_h) - 16'd1;
		swept_box = base_box;
		case (heading)
			sbcu_pkg::HEAD_UP: swept_box.top = base_box.top - 16'(speed);
			sbcu_pkg::HEAD_DOWN: swept_box.bottom = base_box.bottom + 16'(speed);
			sbcu_pkg::HEAD_LEFT: swept_box.left = base_box.left - 16'(speed);
			sbcu_pkg::HEAD_RIGHT: swept_box.right = base_box.right + 16'(speed);
			sbcu_pkg::HEAD_UPLEFT: begin
				swept_box.top = base_box.top - 16'(speed);
				swept_box.left = base_box.left - 16'(speed);
			end
			sbcu_pkg::HEAD_DOWNLEFT: begin
				swept_box.bottom = base_box.bottom + 16'(speed);
				swept_box.left = base_box.left - 16'(speed);
			end
			sbcu_pkg::HEAD_UPRIGHT: begin
				swept_box.top = base_box.top - 16'(speed);
				swept_box.right = base_box.right + 16'(speed);
			end
			sbcu_pkg::HEAD_DOWNRIGHT: begin
				swept_box.bottom = base_box.bottom + 16'(speed);
				swept_box.right = base_box.right + 16'(speed);
			end
			default: swept_box = base_box;
		endcase
	end

	assign wr.valid = in_xfer && (s_tuser == sbcu_pkg::FUNC_WRITE);
	assign wr.slot = s_tdata[3:0];
	assign wr.enable = s_tdata[64];
	assign wr.box = base_box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q <= sbcu_pkg::WORLD_RESET;
			world_h_q <= sbcu_pkg::WORLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sbcu_pkg::REG_WORLD_WIDTH: world_w_q <= cfg_data;
				sbcu_pkg::REG_WORLD_HEIGHT: world_h_q <= cfg_data;
				default: world_w_q <= world_w_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
		end else begin
			head_vld_q <= in_xfer && (s_tuser == sbcu_pkg::FUNC_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		head_box_q <= swept_box;
	end

	assign head_oob = head_box_q.left[sbcu_pkg::EDGE_W-1]
		|| head_box_q.top[sbcu_pkg::EDGE_W-1]
		|| ($signed({head_box_q.right[sbcu_pkg::EDGE_W-1], head_box_q.right})
			>= $signed({2'b00, world_w_q}))
		|| ($signed({head_box_q.bottom[sbcu_pkg::EDGE_W-1], head_box_q.bottom})
			>= $signed({2'b00, world_h_q}));

	assign tok_vld[0] = head_vld_q;
	assign tok[0].done = head_oob;
	assign tok[0].found = 1'b0;
	assign tok[0].idx = '0;
	assign tok[0].box = head_box_q;

	for (genvar k = 0; k < NUM_OBJECTS; k++) begin : g_cell
		sbcu_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr(wr),
			.tok_vld_in(tok_vld[k]),
			.tok_in(tok[k]),
			.tok_vld_out(tok_vld[k+1]),
			.tok_out(tok[k+1])
		);
		assign cell_vld[k] = tok_vld[k+1];
	end

	always_comb begin
		if (tok[NUM_OBJECTS].done) begin
			tail_stat = sbcu_pkg::STAT_OOB;
		end else if (tok[NUM_OBJECTS].found) begin
			tail_stat = sbcu_pkg::STAT_HIT;
		end else begin
			tail_stat = sbcu_pkg::STAT_NONE;
		end
	end

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_xfer && (s_tuser == sbcu_pkg::FUNC_QUERY)) begin
				busy_q <= 1'b1;
			end else if (pend_vld_q && out_free) begin
				busy_q <= 1'b0;
			end
			if (tok_vld[NUM_OBJECTS]) begin
				pend_vld_q <= 1'b1;
			end else if (out_free) begin
				pend_vld_q <= 1'b0;
			end
			if (out_free) begin
				out_vld_q <= pend_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld[NUM_OBJECTS]) begin
			pend_stat_q <= tail_stat;
			pend_slot_q <= (tail_stat == sbcu_pkg::STAT_HIT) ? 4'(tok[NUM_OBJECTS].idx) : 4'd0;
		end
		if (out_free && pend_vld_q) begin
			out_stat_q <= pend_stat_q;
			out_slot_q <= pend_slot_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser = out_stat_q;
	assign m_tdata = 8'(out_slot_q);

	`include "swept_box_object_collision_unit_macros.svh"

	`SBCU_ASSERT_NEXT(a_query_blocks, clk, arst_n, in_xfer && s_tuser == sbcu_pkg::FUNC_QUERY, !s_tready, "query transfer did not close the input")
	`SBCU_ASSERT(a_one_in_flight, clk, arst_n, $countones(cell_vld) <= 1, "more than one query in the cell row")
	`SBCU_ASSERT(a_pend_busy, clk, arst_n, !pend_vld_q || busy_q, "pending result without a query in flight")
	`SBCU_ASSERT(a_slot_zero, clk, arst_n, !m_tvalid || m_tuser == sbcu_pkg::STAT_HIT || m_tdata == 8'd0, "slot set on a result without a hit")

endmodule

[dv/tb_swept_box_object_collision_unit.sv]
module tb_swept_box_object_collision_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SLOTS = sbcu_pkg::NUM_OBJECTS_DEF;
	localparam int GAP_MAX = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int CLUSTER_SPAN = 500;
	localparam logic [3:0] HEAD_UNKNOWN = 4'd15;
	localparam logic [sbcu_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

	typedef struct packed {
		logic func;
		logic [3:0] slot;
		logic [13:0] pos_x;
		logic [13:0] pos_y;
		logic [7:0] off_x;
		logic [7:0] off_y;
		logic [7:0] width;
		logic [7:0] height;
		logic enable;
		logic [3:0] heading;
		logic [7:0] speed;
	} sweep_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] hit_slot;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sbcu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sbcu_pkg::WORLD_W-1:0] cfg_data = '0;

	int obj_left [N_SLOTS];
	int obj_right [N_SLOTS];
	int obj_top [N_SLOTS];
	int obj_bottom [N_SLOTS];
	bit obj_on [N_SLOTS];
	int world_w = int'(sbcu_pkg::WORLD_RESET);
	int world_h = int'(sbcu_pkg::WORLD_RESET);
	outcome_t sweep_outcomes [$];

	bit tx_stall_en = 1'b1;
	bit rx_stall_en = 1'b1;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_gap = 0;
	int quiet_cycles = 0;

	int error_count = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_cfg = 0;
	int n_hits = 0;
	int n_clear = 0;
	int n_oob = 0;

	swept_box_object_collision_unit #(
		.NUM_OBJECTS(N_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		error_count++;
	endtask

	function automatic void box_of(input sweep_item_t it, output int l, output int r,
		output int t, output int b);
		l = int'(it.pos_x) + int'(it.off_x);
		t = int'(it.pos_y) + int'(it.off_y);
		r = l + int'(it.width) - 1;
		b = t + int'(it.height) - 1;
	endfunction

	function automatic outcome_t predict_sweep(input sweep_item_t it);
		int l, r, t, b, spd;
		outcome_t res;
		box_of(it, l, r, t, b);
		spd = int'(it.speed);
		res.status = sbcu_pkg::STAT_NONE;
		res.hit_slot = '0;
		if (it.heading == sbcu_pkg::HEAD_UP || it.heading == sbcu_pkg::HEAD_UPLEFT ||
				it.heading == sbcu_pkg::HEAD_UPRIGHT)
			t -= spd;
		if (it.heading == sbcu_pkg::HEAD_DOWN || it.heading == sbcu_pkg::HEAD_DOWNLEFT ||
				it.heading == sbcu_pkg::HEAD_DOWNRIGHT)
			b += spd;
		if (it.heading == sbcu_pkg::HEAD_LEFT || it.heading == sbcu_pkg::HEAD_UPLEFT ||
				it.heading == sbcu_pkg::HEAD_DOWNLEFT)
			l -= spd;
		if (it.heading == sbcu_pkg::HEAD_RIGHT || it.heading == sbcu_pkg::HEAD_UPRIGHT ||
				it.heading == sbcu_pkg::HEAD_DOWNRIGHT)
			r += spd;
		if (l < 0 || t < 0 || r >= world_w || b >= world_h) begin
			res.status = sbcu_pkg::STAT_OOB;
			return res;
		end
		for (int k = 0; k < N_SLOTS; k++) begin
			if (obj_on[k] && l <= obj_right[k] && r >= obj_left[k] &&
					t <= obj_bottom[k] && b >= obj_top[k]) begin
				res.status = sbcu_pkg::STAT_HIT;
				res.hit_slot = 4'(k);
				return res;
			end
		end
		return res;
	endfunction

	task automatic send_item(input logic func, input int slot, input int px, input int py,
		input int ox, input int oy, input int w, input int h, input logic en,
		input int hd, input int spd);
		sweep_item_t it;
		int gap;
		int l, r, t, b;
		it.func = func;
		it.slot = 4'(slot);
		it.pos_x = 14'(px);
		it.pos_y = 14'(py);
		it.off_x = 8'(ox);
		it.off_y = 8'(oy);
		it.width = 8'(w);
		it.height = 8'(h);
		it.enable = en;
		it.heading = 4'(hd);
		it.speed = 8'(spd);
		gap = tx_stall_en ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.func;
		s_tdata <= {3'b000, it.speed, it.heading, it.enable, it.height, it.width,
			it.off_y, it.off_x, it.pos_y, it.pos_x, it.slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (it.func == sbcu_pkg::FUNC_WRITE) begin
			n_writes++;
			if (int'(it.slot) < N_SLOTS) begin
				box_of(it, l, r, t, b);
				obj_left[it.slot] = l;
				obj_right[it.slot] = r;
				obj_top[it.slot] = t;
				obj_bottom[it.slot] = b;
				obj_on[it.slot] = it.enable;
			end
		end else begin
			n_queries++;
			sweep_outcomes.push_back(predict_sweep(it));
		end
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		while (sweep_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_world(input logic [sbcu_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[sbcu_pkg::WORLD_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_cfg++;
		if (idx == sbcu_pkg::REG_WORLD_WIDTH)
			world_w = int'(value[sbcu_pkg::WORLD_W-1:0]);
		else if (idx == sbcu_pkg::REG_WORLD_HEIGHT)
			world_h = int'(value[sbcu_pkg::WORLD_W-1:0]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random per-result stall, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin : rx_side
		int gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else if (m_tvalid && m_tready) begin
			gap = rx_stall_en ? $urandom_range(0, GAP_MAX) : 0;
			rx_gap <= gap;
			m_tready <= (gap == 0);
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= (rx_gap == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		outcome_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (sweep_outcomes.size() == 0) begin
				flag_mismatch($sformatf("result with none pending: status %0d slot %0d",
					m_tuser, m_tdata));
			end else begin
				exp = sweep_outcomes.pop_front();
				case (exp.status)
					sbcu_pkg::STAT_HIT: n_hits++;
					sbcu_pkg::STAT_OOB: n_oob++;
					default: n_clear++;
				endcase
				if (m_tuser !== exp.status)
					flag_mismatch($sformatf("status got %0d exp %0d", m_tuser, exp.status));
				if (m_tdata !== {4'b0000, exp.hit_slot})
					flag_mismatch($sformatf("hit_slot got %0d exp %0d", m_tdata,
						exp.hit_slot));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("swept_box_object_collision_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_reset_state();
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 255, 255, 1'b1, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 16129, 16129, 0, 0, 255, 255, 1'b0,
			sbcu_pkg::HEAD_DOWNRIGHT, 0);
		settle();
	endtask

	task automatic test_directed();
		tx_stall_en = 1'b1;
		send_item(sbcu_pkg::FUNC_WRITE, 0, 100, 100, 0, 0, 10, 10, 1'b1, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_WRITE, 15, 16383, 16383, 255, 255, 255, 255, 1'b1,
			HEAD_UNKNOWN, 255);
		send_item(sbcu_pkg::FUNC_WRITE, 3, 200, 100, 0, 0, 0, 0, 1'b1, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_WRITE, 7, 300, 300, 5, 5, 20, 20, 1'b1, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_WRITE, 9, 300, 300, 0, 0, 40, 40, 1'b1, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 110, 100, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 110, 100, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_LEFT, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 100, 115, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_UP, 6);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 100, 90, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_DOWN, 6);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 90, 100, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_RIGHT, 5);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 400, 400, 0, 0, 10, 10, 1'b0,
			sbcu_pkg::HEAD_UPLEFT, 255);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 350, 280, 0, 0, 10, 10, 1'b0,
			sbcu_pkg::HEAD_DOWNLEFT, 20);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_UPRIGHT, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 15, 16000, 16000, 255, 255, 255, 255, 1'b1,
			sbcu_pkg::HEAD_DOWNRIGHT, 255);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 5, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_LEFT, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 5, 0, 0, 5, 5, 1'b0, sbcu_pkg::HEAD_LEFT, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 16128, 0, 0, 0, 255, 1, 1'b0,
			sbcu_pkg::HEAD_RIGHT, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 16128, 0, 0, 0, 255, 1, 1'b0,
			sbcu_pkg::HEAD_RIGHT, 2);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 16128, 0, 0, 1, 255, 1'b0,
			sbcu_pkg::HEAD_DOWN, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 100, 100, 0, 0, 1, 1, 1'b0, HEAD_UNKNOWN, 255);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 110, 110, 0, 0, 0, 0, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_WRITE, 0, 100, 100, 0, 0, 10, 10, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 105, 105, 0, 0, 1, 1, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		settle();
	endtask

	task automatic test_world_config();
		write_world(sbcu_pkg::REG_WORLD_WIDTH, 1);
		write_world(sbcu_pkg::REG_WORLD_HEIGHT, 1);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, 1, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 2, 1, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		settle();
		write_world(sbcu_pkg::REG_WORLD_WIDTH, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, 1, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		settle();
		write_world(REG_SPARE, 32767);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, 1, 1'b0, sbcu_pkg::HEAD_NONE, 0);
		settle();
		write_world(sbcu_pkg::REG_WORLD_WIDTH, 32767);
		write_world(sbcu_pkg::REG_WORLD_HEIGHT, 32767);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 16383, 16383, 255, 255, 255, 255, 1'b1,
			sbcu_pkg::HEAD_DOWNRIGHT, 255);
		send_item(sbcu_pkg::FUNC_QUERY, 0, 16383, 0, 255, 0, 255, 1, 1'b0,
			sbcu_pkg::HEAD_RIGHT, 255);
		settle();
		write_world(sbcu_pkg::REG_WORLD_WIDTH, int'(sbcu_pkg::WORLD_RESET));
		write_world(sbcu_pkg::REG_WORLD_HEIGHT, int'(sbcu_pkg::WORLD_RESET));
	endtask

	task automatic test_backpressure();
		tx_stall_en = 1'b0;
		send_item(sbcu_pkg::FUNC_WRITE, 4, 1000, 1000, 0, 0, 50, 50, 1'b1,
			sbcu_pkg::HEAD_NONE, 0);
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 10; i++)
			send_item(sbcu_pkg::FUNC_QUERY, 0, 980 + 4 * i, 1000, 0, 0, 10, 10, 1'b0,
				$urandom_range(0, 8), $urandom_range(0, 40));
		settle();
		tx_stall_en = 1'b1;
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 6; i++)
			send_item(sbcu_pkg::FUNC_QUERY, 0, 990 + 10 * i, 990, 0, 0, 20, 20, 1'b0,
				sbcu_pkg::HEAD_NONE, 0);
		await_results();
		for (int i = 0; i < 6; i++)
			send_item(sbcu_pkg::FUNC_QUERY, 0, 1000, 960 + 15 * i, 0, 0, 20, 20, 1'b0,
				sbcu_pkg::HEAD_DOWN, 10);
		settle();
	endtask

	task automatic test_random();
		int kind, lim, base_x, base_y;
		int px, py, hd;
		bit is_write, wide;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			kind = (ph == 0) ? 0 : $urandom_range(0, 4);
			case (kind)
				0: begin
					write_world(sbcu_pkg::REG_WORLD_WIDTH, int'(sbcu_pkg::WORLD_RESET));
					write_world(sbcu_pkg::REG_WORLD_HEIGHT, int'(sbcu_pkg::WORLD_RESET));
				end
				1: begin
					write_world(sbcu_pkg::REG_WORLD_WIDTH, 32767);
					write_world(sbcu_pkg::REG_WORLD_HEIGHT, $urandom_range(600, 32767));
				end
				2: begin
					write_world(sbcu_pkg::REG_WORLD_WIDTH, $urandom_range(1, 2000));
					write_world(sbcu_pkg::REG_WORLD_HEIGHT, $urandom_range(1, 2000));
				end
				default: begin
					write_world(sbcu_pkg::REG_WORLD_WIDTH, $urandom_range(1, 16384));
					write_world(sbcu_pkg::REG_WORLD_HEIGHT, $urandom_range(1, 16384));
				end
			endcase
			tx_stall_en = ($urandom_range(0, 3) != 0);
			rx_stall_en <= ($urandom_range(0, 3) != 0);
			lim = ((world_w < world_h) ? world_w : world_h) - CLUSTER_SPAN - 800;
			if (lim > 16383 - CLUSTER_SPAN)
				lim = 16383 - CLUSTER_SPAN;
			base_x = (lim > 0) ? $urandom_range(0, lim) : 0;
			base_y = (lim > 0) ? $urandom_range(0, lim) : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				is_write = ($urandom_range(0, 9) < 4);
				wide = ($urandom_range(0, 4) == 0);
				px = wide ? $urandom_range(0, 16383) : base_x + $urandom_range(0, CLUSTER_SPAN);
				py = wide ? $urandom_range(0, 16383) : base_y + $urandom_range(0, CLUSTER_SPAN);
				hd = ($urandom_range(0, 12) < 9) ? $urandom_range(0, 8) : $urandom_range(9, 15);
				send_item(is_write ? sbcu_pkg::FUNC_WRITE : sbcu_pkg::FUNC_QUERY,
					$urandom_range(0, 15), px, py,
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), ($urandom_range(0, 3) != 0), hd,
					$urandom_range(0, 255));
			end
			settle();
		end
		rx_stall_en <= 1'b1;
	endtask

	initial begin
		for (int k = 0; k < N_SLOTS; k++)
			obj_on[k] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_world_config();
		test_backpressure();
		test_sender_pause();
		test_random();
		settle();
		$display("covered %0d items (%0d slot writes, %0d queries), %0d world register writes",
			n_writes + n_queries, n_writes, n_queries, n_cfg);
		$display("checked %0d hits, %0d clear, %0d out of bounds; %0d mismatches",
			n_hits, n_clear, n_oob, error_count);
		if (error_count == 0) begin
			$display("swept_box_object_collision_unit verification clean");
		end else begin
			$display("swept_box_object_collision_unit verification failed");
		end
		$finish;
	end

endmodule
